@@ hw/rtl/watchpoint_slot_manager_macros.svh @@
// Assertion helpers shared by the watchpoint slot manager RTL.
// WPSM_ASSERT expects clk_i and rst_ni in the enclosing module; WPSM_ASSERT_ALWAYS needs only clk_i.
`ifndef WATCHPOINT_SLOT_MANAGER_MACROS_SVH
`define WATCHPOINT_SLOT_MANAGER_MACROS_SVH

// Checked on every rising edge outside reset.
`define WPSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define WPSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/wpsm_pkg.sv @@
`default_nettype none

package wpsm_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned LenW  = 8;
  localparam int unsigned BasW  = 8;
  localparam int unsigned TypeW = 2;
  localparam int unsigned CtrlW = 30;
  localparam int unsigned SlotW = 4;

  // Length saturates at eight bytes, the width of the byte-select mask.
  localparam logic [LenW-1:0]  MaxLen  = 8'd8;
  localparam logic [BasW-1:0]  FullBas = 8'hFF;
  localparam logic [1:0]       PrivVal = 2'b11;
  localparam logic [1:0]       SecVal  = 2'b01;
  localparam logic             HmcVal  = 1'b1;

  // Control word fields.
  localparam int unsigned CtrlEnBit   = 0;
  localparam int unsigned CtrlTypeLo  = 3;
  localparam int unsigned CtrlBasHi   = 12;

  typedef enum logic {
    OpAdd    = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [BasW-1:0]  bas;
    logic [TypeW-1:0] typ;
    logic [CtrlW-1:0] ctrl;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [SlotW-1:0] slot;
    logic             already_present;
    logic [CtrlW-1:0] control_word;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/wpsm_decode.sv @@
`default_nettype none

// Turns a raw request into the byte-select mask, access type and the
// control word that a new slot would receive.
module wpsm_decode (
  input  wpsm_pkg::op_e                   op_i,
  input  logic [wpsm_pkg::AddrW-1:0]      address_i,
  input  logic [wpsm_pkg::LenW-1:0]       length_i,
  input  logic                            on_read_i,
  input  logic                            on_write_i,
  output wpsm_pkg::req_t                  req_o
);

  logic [wpsm_pkg::LenW-1:0] len_clamped;
  logic [wpsm_pkg::BasW:0]   ones;
  logic [wpsm_pkg::BasW-1:0] bas;
  logic [wpsm_pkg::TypeW-1:0] typ;

  assign len_clamped = (length_i > wpsm_pkg::MaxLen) ? wpsm_pkg::MaxLen : length_i;
  // A clamped length of at most eight fits in four bits; eight gives all ones.
  assign ones = ((wpsm_pkg::BasW+1)'(1) << len_clamped[3:0]) - (wpsm_pkg::BasW+1)'(1);
  assign bas  = ones[wpsm_pkg::BasW-1:0] & wpsm_pkg::FullBas;
  assign typ  = {on_write_i, on_read_i};

  assign req_o.op   = op_i;
  assign req_o.addr = address_i;
  assign req_o.bas  = bas;
  assign req_o.typ  = typ;
  assign req_o.ctrl = {{(wpsm_pkg::CtrlW-16){1'b0}}, wpsm_pkg::SecVal, wpsm_pkg::HmcVal,
                       bas, typ, wpsm_pkg::PrivVal, 1'b1};

endmodule

`default_nettype wire

@@ hw/rtl/wpsm_slot_file.sv @@
`default_nettype none

`include "watchpoint_slot_manager_macros.svh"

// Slot registers with a parallel match and a lowest-free search. The result
// for the presented request is combinational; state changes when upd_i is high.
module wpsm_slot_file #(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_i,
  input  wpsm_pkg::req_t req_i,
  output wpsm_pkg::res_t res_o
);

  logic [wpsm_pkg::CtrlW-1:0] ctrl_q [SLOT_COUNT];
  logic [wpsm_pkg::AddrW-1:0] addr_q [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] en;
  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] hit_first;
  logic [SLOT_COUNT-1:0] free_first;
  logic                  hit_any;
  logic                  free_any;
  logic [wpsm_pkg::CtrlW-1:0] hit_ctrl;
  logic [wpsm_pkg::SlotW-1:0] hit_slot;
  logic [wpsm_pkg::SlotW-1:0] free_slot;
  logic                  do_add;
  logic                  do_remove;

  always_comb begin
    logic hit_seen;
    logic free_seen;
    hit_seen  = 1'b0;
    free_seen = 1'b0;
    hit_ctrl  = '0;
    hit_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      en[i]  = ctrl_q[i][wpsm_pkg::CtrlEnBit];
      hit[i] = en[i] &&
               (ctrl_q[i][wpsm_pkg::CtrlBasHi:wpsm_pkg::CtrlTypeLo] == {req_i.bas, req_i.typ}) &&
               (addr_q[i] == req_i.addr);
      hit_first[i]  = hit[i] && !hit_seen;
      free_first[i] = !en[i] && !free_seen;
      hit_seen  = hit_seen || hit[i];
      free_seen = free_seen || !en[i];
      hit_ctrl  = hit_ctrl | (ctrl_q[i] & {wpsm_pkg::CtrlW{hit_first[i]}});
      hit_slot  = hit_slot | (wpsm_pkg::SlotW'(i) & {wpsm_pkg::SlotW{hit_first[i]}});
      free_slot = free_slot | (wpsm_pkg::SlotW'(i) & {wpsm_pkg::SlotW{free_first[i]}});
    end
    hit_any  = hit_seen;
    free_any = free_seen;
  end

  assign do_remove = hit_any && (req_i.op == wpsm_pkg::OpRemove);
  assign do_add    = !hit_any && free_any && (req_i.op == wpsm_pkg::OpAdd);

  always_comb begin
    res_o = '0;
    if (hit_any) begin
      res_o.ok              = 1'b1;
      res_o.slot            = hit_slot;
      res_o.already_present = (req_i.op == wpsm_pkg::OpAdd);
      res_o.control_word    = hit_ctrl;
    end else if (do_add) begin
      res_o.ok           = 1'b1;
      res_o.slot         = free_slot;
      res_o.control_word = req_i.ctrl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        ctrl_q[i] <= '0;
      end
    end else if (upd_i) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (do_remove && hit_first[i]) begin
          ctrl_q[i] <= '0;
        end else if (do_add && free_first[i]) begin
          ctrl_q[i] <= req_i.ctrl;
        end
      end
    end
  end

  // Addresses are only looked at while the slot is enabled, so no reset.
  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (do_add && free_first[i]) begin
          addr_q[i] <= req_i.addr;
        end
      end
    end
  end

  `WPSM_ASSERT(a_one_slot_per_word, $countones(en ^ $past(en)) <= 1, "more than one slot changed")
  `WPSM_ASSERT(a_add_fail_only_full, (upd_i && req_i.op == wpsm_pkg::OpAdd && !res_o.ok) |-> (&en), "add failed with a free slot")
  `WPSM_ASSERT(a_remove_clears, (upd_i && do_remove) |=> ((en & $past(hit_first)) == '0), "removed slot still enabled")
  `WPSM_ASSERT(a_add_enables, (upd_i && do_add) |=> ((en & $past(free_first)) == $past(free_first)), "added slot not enabled")

endmodule

`default_nettype wire

@@ hw/rtl/watchpoint_slot_manager.sv @@
`default_nettype none

// Watchpoint slot manager: each request word (add or remove one data
// watchpoint) yields exactly one result word. A request is taken into an
// input register; once the result register is free, the slot file matches it
// against all slots in parallel, picks the lowest free slot, updates the
// slots and loads the result register, so the block sustains one request
// per clock while the output is not stalled, and the result word reaches the
// output through the input register and then the result register. The
// slot file search is combinational; a stalled output holds the pipeline only
// once both registers are full. All slots are disabled by reset at once, with no clearing pass.
module watchpoint_slot_manager #(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address[63:0], length[71:64], on_read[72], on_write[73], zero[79:74]
  input  logic [79:0] s_axis_tdata,
  // operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ok[0], slot[4:1], already_present[5], control_word[35:6], zero[39:36]
  output logic [39:0] m_axis_tdata
);

  logic                        in_valid_q;
  wpsm_pkg::op_e               op_q;
  logic [wpsm_pkg::AddrW-1:0]  addr_q;
  logic [wpsm_pkg::LenW-1:0]   len_q;
  logic                        rd_q;
  logic                        wr_q;
  logic                        out_valid_q;
  wpsm_pkg::res_t              res_q;

  wpsm_pkg::req_t              req;
  wpsm_pkg::res_t              res;
  logic                        out_free;
  logic                        advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= wpsm_pkg::op_e'(s_axis_tuser);
      addr_q <= s_axis_tdata[63:0];
      len_q  <= s_axis_tdata[71:64];
      rd_q   <= s_axis_tdata[72];
      wr_q   <= s_axis_tdata[73];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  wpsm_decode u_decode (
    .op_i       (op_q),
    .address_i  (addr_q),
    .length_i   (len_q),
    .on_read_i  (rd_q),
    .on_write_i (wr_q),
    .req_o      (req)
  );

  wpsm_slot_file #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_file (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance),
    .req_i  (req),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.control_word, res_q.already_present,
                          res_q.slot, res_q.ok};

endmodule

`default_nettype wire
